// ===== rtl/ocar_pkg.sv =====
// shared types and codes for the one-counter automaton runner
package ocar_pkg;

  // request op codes on the input channel
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FEED  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START_STATE = 2'd0;
  localparam logic [1:0] CFG_LEVEL_CAP   = 2'd1;
  localparam logic [1:0] CFG_ACCEPT_MASK = 2'd2;

  // request kinds held in the queue
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_FEED  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic              valid;
    logic [3:0]        dest;
    logic signed [7:0] effect;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] symbol;
    logic [3:0] src_state;
    logic [3:0] level;
    entry_t     entry;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  start_state;
    logic [3:0]  level_cap;
    logic [15:0] accepting_mask;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic        dead;
    logic [15:0] final_count;
    logic        overflowed;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic pop;
    logic end_pop;
  } bk_stat_t;

endpackage

// ===== rtl/ocar_ram.sv =====
// generic simple dual-port ram with registered read
module ocar_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ocar_front.sv =====
// front end: takes requests, decodes op and drops those with no effect
module ocar_front #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_LEVELS  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [3:0]        in_symbol,
  input  logic [3:0]        in_src_state,
  input  logic [3:0]        in_level,
  input  logic [3:0]        in_dest_state,
  input  logic signed [7:0] in_effect,
  input  logic              in_entry_valid,
  input  logic              q_full,
  input  ocar_pkg::bk_stat_t bk_stat,
  output logic              push,
  output ocar_pkg::cmd_t    push_cmd
);
  import ocar_pkg::*;

  logic keep;
  logic wr_in_range;

  assign wr_in_range = (32'(in_src_state) < NUM_STATES) &&
                       (32'(in_level) < NUM_LEVELS) &&
                       (32'(in_symbol) < NUM_SYMBOLS);

  always_comb begin
    push_cmd.symbol       = in_symbol;
    push_cmd.src_state    = in_src_state;
    push_cmd.level        = in_level;
    push_cmd.entry.valid  = in_entry_valid;
    push_cmd.entry.dest   = in_dest_state;
    push_cmd.entry.effect = in_effect;
    case (in_op)
      OP_WRITE: begin
        push_cmd.kind = KIND_WRITE;
        keep          = wr_in_range;
      end
      OP_FEED: begin
        push_cmd.kind = KIND_FEED;
        keep          = 1'b1;
      end
      OP_END: begin
        push_cmd.kind = KIND_END;
        keep          = 1'b1;
      end
      default: begin
        // unused op code is consumed and ignored
        push_cmd.kind = KIND_FEED;
        keep          = 1'b0;
      end
    endcase
  end

  assign in_ready = !q_full && !bk_stat.clearing;
  assign push     = in_valid && in_ready && keep;

endmodule

// ===== rtl/ocar_fifo.sv =====
// short request queue between front and back end
module ocar_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ocar_pkg::cmd_t push_cmd,
  input  logic           pop,
  output ocar_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import ocar_pkg::*;

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_pop;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head   = q_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/ocar_back.sv =====
// back end: table clear, table writes, symbol steps and end-of-word results
module ocar_back #(
  parameter int NUM_STATES   = 16,
  parameter int NUM_LEVELS   = 16,
  parameter int NUM_SYMBOLS  = 16,
  parameter int COUNTER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ocar_pkg::cfg_t     cfg,
  input  ocar_pkg::cmd_t     head,
  input  logic               q_empty,
  output ocar_pkg::bk_stat_t bk_stat,
  output logic               out_valid,
  input  logic               out_ready,
  output ocar_pkg::res_t     out_res
);
  import ocar_pkg::*;

  localparam int TBL_DEPTH = NUM_STATES * NUM_LEVELS * NUM_SYMBOLS;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int SW        = ((COUNTER_BITS > 8) ? COUNTER_BITS : 8) + 2;
  localparam logic [3:0] LVL_MAX = (NUM_LEVELS - 1 > 15) ? 4'd15 : 4'(NUM_LEVELS - 1);
  localparam logic [SW-1:0] CNT_MAX = SW'((33'd1 << COUNTER_BITS) - 33'd1);

  localparam logic [1:0] PH_CLEAR = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_LOOK  = 2'd2;

  function automatic logic [AW-1:0] tbl_addr(input logic [3:0] st, input logic [3:0] lvl,
                                             input logic [3:0] sym);
    logic [31:0] a;
    a = (32'(st) * 32'(NUM_LEVELS) + 32'(lvl)) * 32'(NUM_SYMBOLS) + 32'(sym);
    return a[AW-1:0];
  endfunction

  logic [1:0]              phase_r, phase_nxt;
  logic [AW-1:0]           clr_addr_r, clr_addr_nxt;
  logic [3:0]              state_r, state_nxt;
  logic [COUNTER_BITS-1:0] count_r, count_nxt;
  logic                    dead_r, dead_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    begun_r, begun_nxt;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    out_res_r, out_res_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;

  logic [3:0]    st_eff;
  logic [3:0]    cap_eff;
  logic [3:0]    lvl;
  logic [SW-1:0] sum;
  logic          sum_neg;
  logic          sum_ovf;
  logic          out_free;

  ocar_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // a word takes the start state as it stands at its first request
  assign st_eff  = begun_r ? state_r : cfg.start_state;
  assign cap_eff = (cfg.level_cap > LVL_MAX) ? LVL_MAX : cfg.level_cap;
  assign lvl     = (count_r > COUNTER_BITS'(cap_eff)) ? cap_eff : count_r[3:0];

  assign sum     = SW'(count_r) + SW'(rd_entry.effect);
  assign sum_neg = sum[SW-1];
  assign sum_ovf = !sum_neg && (sum > CNT_MAX);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt        = phase_r;
    clr_addr_nxt     = clr_addr_r;
    state_nxt        = state_r;
    count_nxt        = count_r;
    dead_nxt         = dead_r;
    ovf_nxt          = ovf_r;
    begun_nxt        = begun_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_res_nxt      = out_res_r;
    ram_we           = 1'b0;
    ram_waddr        = tbl_addr(head.src_state, head.level, head.symbol);
    ram_wdata        = ENTRY_W'(head.entry);
    ram_raddr        = tbl_addr(st_eff, lvl, head.symbol);
    bk_stat.clearing = 1'b0;
    bk_stat.pop      = 1'b0;
    bk_stat.end_pop  = 1'b0;

    case (phase_r)
      PH_CLEAR: begin
        bk_stat.clearing = 1'b1;
        ram_we           = 1'b1;
        ram_waddr        = clr_addr_r;
        ram_wdata        = '0;
        clr_addr_nxt     = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(TBL_DEPTH - 1)) begin
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN: begin
        if (!q_empty) begin
          case (head.kind)
            KIND_WRITE: begin
              bk_stat.pop = 1'b1;
              ram_we      = 1'b1;
            end
            KIND_FEED: begin
              bk_stat.pop = 1'b1;
              begun_nxt   = 1'b1;
              state_nxt   = st_eff;
              if (!dead_r) begin
                if ((32'(st_eff) >= NUM_STATES) || (32'(head.symbol) >= NUM_SYMBOLS)) begin
                  dead_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_LOOK;
                end
              end
            end
            KIND_END: begin
              if (out_free) begin
                bk_stat.pop             = 1'b1;
                bk_stat.end_pop         = 1'b1;
                out_valid_nxt           = 1'b1;
                out_res_nxt.accepted    = !dead_r && (count_r == '0) &&
                                          cfg.accepting_mask[st_eff];
                out_res_nxt.dead        = dead_r;
                out_res_nxt.final_count = dead_r ? 16'd0 : 16'(count_r);
                out_res_nxt.overflowed  = ovf_r;
                state_nxt               = cfg.start_state;
                count_nxt               = '0;
                dead_nxt                = 1'b0;
                ovf_nxt                 = 1'b0;
                begun_nxt               = 1'b0;
              end
            end
            default: begin
              bk_stat.pop = 1'b1;
            end
          endcase
        end
      end
      PH_LOOK: begin
        // table entry read last cycle is now on the ram output
        phase_nxt = PH_RUN;
        if (!rd_entry.valid) begin
          dead_nxt = 1'b1;
        end else begin
          state_nxt = rd_entry.dest;
          if (sum_neg) begin
            dead_nxt = 1'b1;
          end else if (sum_ovf) begin
            dead_nxt = 1'b1;
            ovf_nxt  = 1'b1;
          end else begin
            count_nxt = sum[COUNTER_BITS-1:0];
          end
        end
      end
      default: begin
        phase_nxt = PH_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLEAR;
      clr_addr_r  <= '0;
      state_r     <= '0;
      count_r     <= '0;
      dead_r      <= 1'b0;
      ovf_r       <= 1'b0;
      begun_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      clr_addr_r  <= clr_addr_nxt;
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dead_r      <= dead_nxt;
      ovf_r       <= ovf_nxt;
      begun_r     <= begun_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/one_counter_automaton_runner.sv =====
// One-counter automaton runner: the input side takes one request per cycle while its
// four-entry queue has room, also while a result waits on the output register. In the
// back end a symbol is looked up in the run phase and its table entry applied in the
// look phase (a word that is dead skips the lookup): the transition table sits in
// synchronous ram and the next lookup address needs the state and counter that the
// previous lookup produced. After reset the table is cleared one entry per cycle, all
// NUM_STATES*NUM_LEVELS*NUM_SYMBOLS entries (4096 with the defaults), with in_ready
// low; configuration writes are taken throughout.
module one_counter_automaton_runner #(
  parameter int NUM_STATES   = 16,
  parameter int NUM_LEVELS   = 16,
  parameter int NUM_SYMBOLS  = 16,
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [3:0]        in_symbol,
  input  logic [3:0]        in_src_state,
  input  logic [3:0]        in_level,
  input  logic [3:0]        in_dest_state,
  input  logic signed [7:0] in_effect,
  input  logic              in_entry_valid,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_accepted,
  output logic              out_dead,
  output logic [15:0]       out_final_count,
  output logic              out_overflowed,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import ocar_pkg::*;

  cfg_t     cfg_r;
  cmd_t     push_cmd;
  cmd_t     head;
  logic     push;
  logic     q_empty;
  logic     q_full;
  bk_stat_t bk_stat;
  res_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_state    <= 4'd0;
      cfg_r.level_cap      <= 4'd15;
      cfg_r.accepting_mask <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_STATE: cfg_r.start_state    <= cfg_data[3:0];
        CFG_LEVEL_CAP:   cfg_r.level_cap      <= cfg_data[3:0];
        CFG_ACCEPT_MASK: cfg_r.accepting_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ocar_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_LEVELS  (NUM_LEVELS),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_symbol      (in_symbol),
    .in_src_state   (in_src_state),
    .in_level       (in_level),
    .in_dest_state  (in_dest_state),
    .in_effect      (in_effect),
    .in_entry_valid (in_entry_valid),
    .q_full         (q_full),
    .bk_stat        (bk_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  ocar_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (bk_stat.pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ocar_back #(
    .NUM_STATES   (NUM_STATES),
    .NUM_LEVELS   (NUM_LEVELS),
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_empty   (q_empty),
    .bk_stat   (bk_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_accepted    = out_res.accepted;
  assign out_dead        = out_res.dead;
  assign out_final_count = out_res.final_count;
  assign out_overflowed  = out_res.overflowed;

  // no request taken during the table clear
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> !in_ready)
    else $error("request accepted during table clear");

  // the queue is never written when full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("queue overrun");

  // a new result only follows an end-of-word request leaving the queue
  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.end_pop))
    else $error("result without end of word");

  // a dead or accepting verdict never comes together
  a_verdict_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_dead))
    else $error("word both accepted and dead");

endmodule
